// File: rtl/lrs_pkg.sv
// Shared types and constants for the labelled region statistics unit.
`default_nettype none
package lrs_pkg;

  typedef struct packed {
    logic signed [15:0] density;
    logic [15:0]        spatial_label;
    logic [15:0]        region_label;
    logic [11:0]        column;
    logic [11:0]        row;
    logic [11:0]        layer;
    logic               last_voxel;
  } voxel_t;

  typedef struct packed {
    logic signed [15:0] min_density;
    logic signed [15:0] max_density;
    logic [24:0]        voxel_count;
    logic signed [23:0] density_mean;
    logic [23:0]        density_stddev;
    logic [19:0]        x_mean;
    logic [19:0]        y_mean;
    logic [18:0]        x_stddev;
    logic [18:0]        y_stddev;
    logic               empty_res;
  } result_t;

  // classified voxel, as held in the queue between front and back
  typedef struct packed {
    logic               hit;
    logic signed [15:0] density;
    logic [11:0]        column;
    logic [11:0]        row;
    logic [30:0]        dens_sq;
    logic [23:0]        col_sq;
    logic [23:0]        row_sq;
    logic               last;
  } entry_t;

  typedef struct packed {
    logic [15:0]        target;
    logic               use_spatial;
    logic [11:0]        layer_sel;
    logic signed [15:0] init_min;
    logic signed [15:0] init_max;
  } cfg_t;

  // accumulator contents handed over at the end of a scan
  typedef struct packed {
    logic signed [15:0] run_min;
    logic signed [15:0] run_max;
    logic [24:0]        count;
    logic signed [39:0] dens_sum;
    logic [54:0]        dens_sq_sum;
    logic [35:0]        col_sum;
    logic [35:0]        row_sum;
    logic [47:0]        col_sq_sum;
    logic [47:0]        row_sq_sum;
  } snap_t;

  typedef enum logic [2:0] {
    REG_TARGET      = 3'd0,
    REG_USE_SPATIAL = 3'd1,
    REG_LAYER       = 3'd2,
    REG_INIT_MIN    = 3'd3,
    REG_INIT_MAX    = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    FIN_IDLE,
    FIN_PREP,
    FIN_NQ,
    FIN_SS,
    FIN_NN,
    FIN_VAR,
    FIN_ROOT,
    FIN_MEAN,
    FIN_OUT
  } fin_state_e;

  typedef enum logic [1:0] {
    STAT_DENS = 2'd0,
    STAT_COL  = 2'd1,
    STAT_ROW  = 2'd2
  } stat_e;

  localparam logic signed [15:0] INIT_MIN_RST = 16'sh7FFF;
  localparam logic signed [15:0] INIT_MAX_RST = 16'sh8000;

  localparam logic [6:0] MUL_STEPS  = 7'd39;
  localparam logic [6:0] DIV_STEPS  = 7'd95;
  localparam logic [6:0] ROOT_STEPS = 7'd31;

endpackage
`default_nettype wire

// File: rtl/lrs_stream_if.sv
// Valid/ready stream channel carrying one payload.
`default_nettype none
interface lrs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/lrs_front.sv
// Front end: takes voxels, classifies them and precomputes the squares.
`default_nettype none
module lrs_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  lrs_stream_if.sink      vox_i,
  input  lrs_pkg::cfg_t   cfg_i,
  input  logic            q_full_i,
  output logic            push_o,
  output lrs_pkg::entry_t entry_o
);

  logic [15:0]        label;
  logic               in_frame;
  logic signed [31:0] dens_sq_full;
  logic [23:0]        col_sq;
  logic [23:0]        row_sq;

  assign vox_i.ready = !q_full_i;
  assign push_o      = vox_i.valid && !q_full_i;

  assign label    = cfg_i.use_spatial ? vox_i.data.spatial_label : vox_i.data.region_label;
  assign in_frame = ({1'b0, vox_i.data.column} < 13'(MAX_WIDTH)) &&
                    ({1'b0, vox_i.data.row} < 13'(MAX_HEIGHT));

  assign dens_sq_full = vox_i.data.density * vox_i.data.density;
  assign col_sq       = vox_i.data.column * vox_i.data.column;
  assign row_sq       = vox_i.data.row * vox_i.data.row;

  always_comb begin
    entry_o.hit     = (vox_i.data.layer == cfg_i.layer_sel) && (label == cfg_i.target) &&
                      in_frame;
    entry_o.density = vox_i.data.density;
    entry_o.column  = vox_i.data.column;
    entry_o.row     = vox_i.data.row;
    entry_o.dens_sq = dens_sq_full[30:0];
    entry_o.col_sq  = col_sq;
    entry_o.row_sq  = row_sq;
    entry_o.last    = vox_i.data.last_voxel;
  end

endmodule
`default_nettype wire

// File: rtl/lrs_queue.sv
// Two-entry queue between front and back.
`default_nettype none
module lrs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lrs_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output lrs_pkg::entry_t entry_o
);

  lrs_pkg::entry_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      fill_q;

  assign full_o  = fill_q[1];
  assign empty_o = (fill_q == 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i)      fill_q <= fill_q + 2'd1;
      else if (pop_i && !push_i) fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule
`default_nettype wire

// File: rtl/lrs_accum.sv
// Back end, first half: running min, max, count and moment sums.
`default_nettype none
module lrs_accum #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lrs_pkg::cfg_t   cfg_i,
  input  logic            init_min_wr_i,
  input  logic            init_max_wr_i,
  input  logic [15:0]     cfg_wdata_i,
  input  logic            q_empty_i,
  input  lrs_pkg::entry_t entry_i,
  output logic            pop_o,
  input  logic            fin_ready_i,
  output logic            start_o,
  output lrs_pkg::snap_t  snap_o
);

  localparam logic [24:0] CountLimit = 25'(MAX_WIDTH * MAX_HEIGHT);

  lrs_pkg::snap_t acc_q;
  logic           hit;

  // a scan end waits until the finisher is free
  assign pop_o   = !q_empty_i && (!entry_i.last || fin_ready_i);
  assign start_o = pop_o && entry_i.last;
  assign hit     = entry_i.hit && (acc_q.count < CountLimit);

  always_comb begin
    snap_o = acc_q;
    if (hit) begin
      if (entry_i.density < acc_q.run_min) snap_o.run_min = entry_i.density;
      if (entry_i.density > acc_q.run_max) snap_o.run_max = entry_i.density;
      snap_o.count       = acc_q.count + 25'd1;
      snap_o.dens_sum    = acc_q.dens_sum + {{24{entry_i.density[15]}}, entry_i.density};
      snap_o.dens_sq_sum = acc_q.dens_sq_sum + 55'(entry_i.dens_sq);
      snap_o.col_sum     = acc_q.col_sum + 36'(entry_i.column);
      snap_o.row_sum     = acc_q.row_sum + 36'(entry_i.row);
      snap_o.col_sq_sum  = acc_q.col_sq_sum + 48'(entry_i.col_sq);
      snap_o.row_sq_sum  = acc_q.row_sq_sum + 48'(entry_i.row_sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q         <= '0;
      acc_q.run_min <= lrs_pkg::INIT_MIN_RST;
      acc_q.run_max <= lrs_pkg::INIT_MAX_RST;
    end else if (pop_o) begin
      if (entry_i.last) begin
        acc_q         <= '0;
        acc_q.run_min <= cfg_i.init_min;
        acc_q.run_max <= cfg_i.init_max;
      end else begin
        acc_q <= snap_o;
      end
    end else if (acc_q.count == 25'd0) begin
      if (init_min_wr_i) acc_q.run_min <= cfg_wdata_i;
      if (init_max_wr_i) acc_q.run_max <= cfg_wdata_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/lrs_finish.sv
// Back end, second half: shift-add multiplier, restoring divider, bitwise root.
`default_nettype none
module lrs_finish (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  lrs_pkg::snap_t snap_i,
  output logic           ready_o,
  lrs_stream_if.source   res_o
);

  lrs_pkg::fin_state_e state_q, state_d;
  lrs_pkg::snap_t      snap_q;
  lrs_pkg::result_t    res_q;
  lrs_pkg::stat_e      k_q;
  logic [6:0]          cnt_q;
  logic [95:0]         mul_a_q, mul_acc_q, p1_q, div_num_q;
  logic [39:0]         mul_b_q;
  logic [49:0]         div_rem_q, div_den_q;
  logic [63:0]         sq_x_q, sq_res_q, sq_one_q;

  logic        last_step, dens_neg, div_ge, sq_ge;
  logic [39:0] dens_mag, cur_mag;
  logic [54:0] cur_sq;
  logic [95:0] mul_acc_nx, var_diff, div_num_nx, quo_neg;
  logic [50:0] div_trial, div_sub;
  logic [49:0] div_rem_nx;
  logic [63:0] sq_t, sq_res_nx;
  logic [47:0] mean_num;

  assign last_step = (cnt_q == 7'd0);
  assign dens_neg  = snap_q.dens_sum[39];
  assign dens_mag  = dens_neg ? 40'(-snap_q.dens_sum) : 40'(snap_q.dens_sum);

  always_comb begin
    case (k_q)
      lrs_pkg::STAT_DENS: begin
        cur_mag = dens_mag;
        cur_sq  = snap_q.dens_sq_sum;
      end
      lrs_pkg::STAT_COL: begin
        cur_mag = 40'(snap_q.col_sum);
        cur_sq  = 55'(snap_q.col_sq_sum);
      end
      default: begin
        cur_mag = 40'(snap_q.row_sum);
        cur_sq  = 55'(snap_q.row_sq_sum);
      end
    endcase
  end

  assign mul_acc_nx = mul_acc_q + (mul_b_q[0] ? mul_a_q : 96'd0);
  assign var_diff   = (p1_q >= mul_acc_nx) ? p1_q - mul_acc_nx : 96'd0;

  assign div_trial  = {div_rem_q, div_num_q[95]};
  assign div_sub    = div_trial - {1'b0, div_den_q};
  assign div_ge     = (div_trial >= {1'b0, div_den_q});
  assign div_rem_nx = div_ge ? div_sub[49:0] : div_trial[49:0];
  assign div_num_nx = {div_num_q[94:0], div_ge};
  assign quo_neg    = 96'd0 - div_num_nx;

  assign sq_t      = sq_res_q + sq_one_q;
  assign sq_ge     = (sq_x_q >= sq_t);
  assign sq_res_nx = sq_ge ? (sq_res_q >> 1) + sq_one_q : sq_res_q >> 1;

  // mean rounds to nearest, ties away from zero
  assign mean_num = {cur_mag, 8'b0} + 48'(snap_q.count >> 1);

  assign ready_o    = (state_q == lrs_pkg::FIN_IDLE);
  assign res_o.valid = (state_q == lrs_pkg::FIN_OUT);
  assign res_o.data  = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lrs_pkg::FIN_IDLE:
        if (start_i) state_d = (snap_i.count == 25'd0) ? lrs_pkg::FIN_OUT : lrs_pkg::FIN_PREP;
      lrs_pkg::FIN_PREP: state_d = lrs_pkg::FIN_NQ;
      lrs_pkg::FIN_NQ:   if (last_step) state_d = lrs_pkg::FIN_SS;
      lrs_pkg::FIN_SS:   if (last_step) state_d = lrs_pkg::FIN_NN;
      lrs_pkg::FIN_NN:   if (last_step) state_d = lrs_pkg::FIN_VAR;
      lrs_pkg::FIN_VAR:  if (last_step) state_d = lrs_pkg::FIN_ROOT;
      lrs_pkg::FIN_ROOT: if (last_step) state_d = lrs_pkg::FIN_MEAN;
      lrs_pkg::FIN_MEAN:
        if (last_step) begin
          state_d = (k_q == lrs_pkg::STAT_ROW) ? lrs_pkg::FIN_OUT : lrs_pkg::FIN_PREP;
        end
      lrs_pkg::FIN_OUT:  if (res_o.ready) state_d = lrs_pkg::FIN_IDLE;
      default:           state_d = lrs_pkg::FIN_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrs_pkg::FIN_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lrs_pkg::FIN_IDLE: begin
        if (start_i) begin
          snap_q               <= snap_i;
          k_q                  <= lrs_pkg::STAT_DENS;
          res_q                <= '0;
          res_q.min_density    <= snap_i.run_min;
          res_q.max_density    <= snap_i.run_max;
          res_q.voxel_count    <= snap_i.count;
          res_q.empty_res      <= (snap_i.count == 25'd0);
        end
      end
      lrs_pkg::FIN_PREP: begin
        mul_a_q   <= 96'(cur_sq);
        mul_b_q   <= 40'(snap_q.count);
        mul_acc_q <= 96'd0;
        cnt_q     <= lrs_pkg::MUL_STEPS;
      end
      lrs_pkg::FIN_NQ, lrs_pkg::FIN_SS, lrs_pkg::FIN_NN: begin
        mul_acc_q <= mul_acc_nx;
        mul_a_q   <= mul_a_q << 1;
        mul_b_q   <= mul_b_q >> 1;
        cnt_q     <= cnt_q - 7'd1;
        if (last_step) begin
          mul_acc_q <= 96'd0;
          cnt_q     <= lrs_pkg::MUL_STEPS;
          if (state_q == lrs_pkg::FIN_NQ) begin
            p1_q    <= mul_acc_nx;
            mul_a_q <= 96'(cur_mag);
            mul_b_q <= cur_mag;
          end else if (state_q == lrs_pkg::FIN_SS) begin
            div_num_q <= {var_diff[79:0], 16'b0};
            mul_a_q   <= 96'(snap_q.count);
            mul_b_q   <= 40'(snap_q.count);
          end else begin
            div_den_q <= mul_acc_nx[49:0];
            div_rem_q <= 50'd0;
            cnt_q     <= lrs_pkg::DIV_STEPS;
          end
        end
      end
      lrs_pkg::FIN_VAR, lrs_pkg::FIN_MEAN: begin
        div_rem_q <= div_rem_nx;
        div_num_q <= div_num_nx;
        cnt_q     <= cnt_q - 7'd1;
        if (last_step) begin
          if (state_q == lrs_pkg::FIN_VAR) begin
            sq_x_q   <= div_num_nx[63:0];
            sq_res_q <= 64'd0;
            sq_one_q <= 64'h4000_0000_0000_0000;
            cnt_q    <= lrs_pkg::ROOT_STEPS;
          end else begin
            case (k_q)
              lrs_pkg::STAT_DENS: begin
                res_q.density_mean <= dens_neg ? quo_neg[23:0] : div_num_nx[23:0];
                k_q                <= lrs_pkg::STAT_COL;
              end
              lrs_pkg::STAT_COL: begin
                res_q.x_mean <= div_num_nx[19:0];
                k_q          <= lrs_pkg::STAT_ROW;
              end
              default: res_q.y_mean <= div_num_nx[19:0];
            endcase
          end
        end
      end
      lrs_pkg::FIN_ROOT: begin
        if (sq_ge) sq_x_q <= sq_x_q - sq_t;
        sq_res_q <= sq_res_nx;
        sq_one_q <= sq_one_q >> 2;
        cnt_q    <= cnt_q - 7'd1;
        if (last_step) begin
          case (k_q)
            lrs_pkg::STAT_DENS: res_q.density_stddev <= sq_res_nx[23:0];
            lrs_pkg::STAT_COL:  res_q.x_stddev       <= sq_res_nx[18:0];
            default:            res_q.y_stddev       <= sq_res_nx[18:0];
          endcase
          div_num_q <= {48'd0, mean_num};
          div_den_q <= 50'(snap_q.count);
          div_rem_q <= 50'd0;
          cnt_q     <= lrs_pkg::DIV_STEPS;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/labeled_region_statistics_unit.sv
// Top level of the labelled region statistics unit with its APB register file.
//
// Streams voxels in at one per cycle while the queue is not full, and keeps
// density min/max, count and the first and second moments of density, column
// and row for voxels on the chosen layer whose chosen label equals the target
// segment. A voxel with last_voxel set closes the scan and yields one result
// request: min, max, count and Q.8 means and population standard deviations
// (empty_res set, means and deviations zero, if nothing matched). The front
// classifies and squares each voxel into a two-entry queue; the back adds it
// to the running sums. Closing a scan runs a single shared shift-add
// multiplier, a restoring divider and a bitwise square root three times over,
// then the result waits to be taken. Voxels of the next scan keep flowing
// meanwhile; only its own last voxel waits for the finisher to go idle.
// Registers (32-bit APB, byte address 4*i): 0 target_segment, 1
// use_spatial_label, 2 layer_select, 3 initial_min, 4 initial_max. Writing
// initial_min/max before any voxel of the scan matched also seeds the running
// extreme. Write registers only when the unit is idle.
`default_nettype none
module labeled_region_statistics_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  lrs_stream_if.sink   vox_i,
  lrs_stream_if.source res_o
);

  lrs_pkg::cfg_t     cfg_q;
  lrs_pkg::reg_idx_e reg_idx;
  logic              wr_en, init_min_wr, init_max_wr;

  lrs_pkg::entry_t front_entry, q_entry;
  logic            push, q_full, q_empty, pop;
  logic            fin_ready, fin_start;
  lrs_pkg::snap_t  snap;

  // register file
  assign pready      = 1'b1;
  assign wr_en       = psel && penable && pwrite;
  assign reg_idx     = lrs_pkg::reg_idx_e'(paddr[4:2]);
  assign init_min_wr = wr_en && (reg_idx == lrs_pkg::REG_INIT_MIN);
  assign init_max_wr = wr_en && (reg_idx == lrs_pkg::REG_INIT_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target      <= 16'd0;
      cfg_q.use_spatial <= 1'b0;
      cfg_q.layer_sel   <= 12'd0;
      cfg_q.init_min    <= lrs_pkg::INIT_MIN_RST;
      cfg_q.init_max    <= lrs_pkg::INIT_MAX_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lrs_pkg::REG_TARGET:      cfg_q.target      <= pwdata[15:0];
        lrs_pkg::REG_USE_SPATIAL: cfg_q.use_spatial <= pwdata[0];
        lrs_pkg::REG_LAYER:       cfg_q.layer_sel   <= pwdata[11:0];
        lrs_pkg::REG_INIT_MIN:    cfg_q.init_min    <= pwdata[15:0];
        lrs_pkg::REG_INIT_MAX:    cfg_q.init_max    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lrs_pkg::REG_TARGET:      prdata = 32'(cfg_q.target);
      lrs_pkg::REG_USE_SPATIAL: prdata = 32'(cfg_q.use_spatial);
      lrs_pkg::REG_LAYER:       prdata = 32'(cfg_q.layer_sel);
      lrs_pkg::REG_INIT_MIN:    prdata = {16'd0, cfg_q.init_min};
      lrs_pkg::REG_INIT_MAX:    prdata = {16'd0, cfg_q.init_max};
      default:                  prdata = 32'd0;
    endcase
  end

  // front: classify and square
  lrs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .vox_i    (vox_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (front_entry)
  );

  lrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .entry_o (q_entry)
  );

  // back: accumulate, then finish the scan
  lrs_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .init_min_wr_i (init_min_wr),
    .init_max_wr_i (init_max_wr),
    .cfg_wdata_i   (pwdata[15:0]),
    .q_empty_i     (q_empty),
    .entry_i       (q_entry),
    .pop_o         (pop),
    .fin_ready_i   (fin_ready),
    .start_o       (fin_start),
    .snap_o        (snap)
  );

  lrs_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fin_start),
    .snap_i  (snap),
    .ready_o (fin_ready),
    .res_o   (res_o)
  );

endmodule
`default_nettype wire
